/* rtl/drd_pkg.sv */
// ---------------------------------------------------------------------------
// drd_pkg: shared types and constants for the detector row decoder
// Field widths, configuration register indexes, class codes and the small
// structs that travel between the decoder's modules.
// ---------------------------------------------------------------------------
package drd_pkg;

  localparam int SCORE_W    = 16;
  localparam int COORD_W    = 16;
  localparam int SCALE_W    = 16;
  localparam int CLASS_W    = 3;
  localparam int MAX_CLASSES = 6;
  localparam int POS_W      = 12;
  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DIM_W-1:0] DIM_MAX = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_MIN = 13'd1;

  // class codes with a threshold of their own; the rest share crossing
  localparam logic [CLASS_W-1:0] CLS_BALL     = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_GOALPOST = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_ROBOT    = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BALL_THR  = 3'd0,
    REG_GOAL_THR  = 3'd1,
    REG_ROBOT_THR = 3'd2,
    REG_CROSS_THR = 3'd3,
    REG_OBJ_EN    = 3'd4,
    REG_BOX_SCALE = 3'd5,
    REG_IMG_W     = 3'd6,
    REG_IMG_H     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [SCORE_W-1:0] ball;
    logic [SCORE_W-1:0] goalpost;
    logic [SCORE_W-1:0] robot;
    logic [SCORE_W-1:0] crossing;
  } thr_t;

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [SCORE_W-1:0] conf;
  } det_t;

  // per-stage load enables of the four-stage pipeline
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ld_t;

endpackage

/* rtl/drd_lane.sv */
// ---------------------------------------------------------------------------
// drd_lane: one class score lane
// Scales one class score by objectness (or passes it) and registers it.
// ---------------------------------------------------------------------------
module drd_lane (
  input  logic                         clk,
  input  logic                         ld,
  input  logic                         obj_en,
  input  logic [drd_pkg::SCORE_W-1:0]  obj,
  input  logic [drd_pkg::SCORE_W-1:0]  score,
  output logic [drd_pkg::SCORE_W-1:0]  score_r
);

  logic [2*drd_pkg::SCORE_W-1:0] prod;
  logic [drd_pkg::SCORE_W-1:0]   score_nxt;

  assign prod      = (2*drd_pkg::SCORE_W)'(score) * (2*drd_pkg::SCORE_W)'(obj);
  assign score_nxt = obj_en ? prod[2*drd_pkg::SCORE_W-1:drd_pkg::SCORE_W] : score;

  always_ff @(posedge clk) begin
    if (ld) begin
      score_r <= score_nxt;
    end
  end

endmodule

/* rtl/drd_merge.sv */
// ---------------------------------------------------------------------------
// drd_merge: best-class select and threshold test
// Picks the highest lane score (lowest index on ties), registers the
// winner and flags whether it clears its class threshold.
// ---------------------------------------------------------------------------
module drd_merge #(
  parameter int NUM_CLASSES = 6
) (
  input  logic                         clk,
  input  logic                         ld,
  input  drd_pkg::thr_t                thr,
  input  logic [drd_pkg::SCORE_W-1:0]  scores [NUM_CLASSES],
  output logic                         pass,
  output drd_pkg::det_t                best_r
);

  logic [drd_pkg::SCORE_W-1:0] best_s;
  logic [drd_pkg::CLASS_W-1:0] best_c;
  logic [drd_pkg::SCORE_W-1:0] thr_sel;

  always_comb begin
    best_s = scores[0];
    best_c = '0;
    for (int c = 1; c < NUM_CLASSES; c++) begin
      if (scores[c] > best_s) begin
        best_s = scores[c];
        best_c = drd_pkg::CLASS_W'(c);
      end
    end
  end

  always_comb begin
    unique case (best_c)
      drd_pkg::CLS_BALL:     thr_sel = thr.ball;
      drd_pkg::CLS_GOALPOST: thr_sel = thr.goalpost;
      drd_pkg::CLS_ROBOT:    thr_sel = thr.robot;
      default:               thr_sel = thr.crossing;
    endcase
  end

  assign pass = (best_s >= thr_sel);

  always_ff @(posedge clk) begin
    if (ld) begin
      best_r.cls  <= best_c;
      best_r.conf <= best_s;
    end
  end

endmodule

/* rtl/drd_box.sv */
// ---------------------------------------------------------------------------
// drd_box: corner box scaling and clamping
// Stage 1 multiplies by the scale, stage 2 truncates toward zero, stage 3
// clamps the corner and saturates sizes, stage 4 fits size inside image.
// ---------------------------------------------------------------------------
module drd_box (
  input  logic                                clk,
  input  drd_pkg::pipe_ld_t                   ld,
  input  logic signed [drd_pkg::COORD_W-1:0]  cx,
  input  logic signed [drd_pkg::COORD_W-1:0]  cy,
  input  logic signed [drd_pkg::COORD_W-1:0]  bw,
  input  logic signed [drd_pkg::COORD_W-1:0]  bh,
  input  logic [drd_pkg::SCALE_W-1:0]         scale,
  input  logic [drd_pkg::DIM_W-1:0]           iw,
  input  logic [drd_pkg::DIM_W-1:0]           ih,
  output logic [drd_pkg::POS_W-1:0]           left_r,
  output logic [drd_pkg::POS_W-1:0]           top_r,
  output logic [drd_pkg::DIM_W-1:0]           wd_r,
  output logic [drd_pkg::DIM_W-1:0]           ht_r
);

  localparam int EDGE_W  = drd_pkg::COORD_W + 2;          // 2*c - w
  localparam int SC_W    = drd_pkg::SCALE_W + 1;          // scale as signed
  localparam int EP_W    = EDGE_W + SC_W;                 // edge product
  localparam int SP_W    = drd_pkg::COORD_W + SC_W;       // size product
  localparam int EQ_W    = EP_W - 13;
  localparam int SQ_W    = SP_W - 12;

  // stage 1
  logic signed [EDGE_W-1:0] ax, ay;
  logic signed [SC_W-1:0]   sc_s;
  logic signed [EP_W-1:0]   pl_r, pt_r;
  logic signed [SP_W-1:0]   pw_r, ph_r;

  assign ax   = EDGE_W'(cx) + EDGE_W'(cx) - EDGE_W'(bw);
  assign ay   = EDGE_W'(cy) + EDGE_W'(cy) - EDGE_W'(bh);
  assign sc_s = signed'({1'b0, scale});

  always_ff @(posedge clk) begin
    if (ld.ld1) begin
      pl_r <= EP_W'(ax) * EP_W'(sc_s);
      pt_r <= EP_W'(ay) * EP_W'(sc_s);
      pw_r <= SP_W'(bw) * SP_W'(sc_s);
      ph_r <= SP_W'(bh) * SP_W'(sc_s);
    end
  end

  // stage 2: divide by 2^13 / 2^12, rounding toward zero
  logic signed [EP_W-1:0] pl_adj, pt_adj;
  logic signed [SP_W-1:0] pw_adj, ph_adj;
  logic signed [EQ_W-1:0] l2_r, t2_r;
  logic signed [SQ_W-1:0] w2_r, h2_r;

  assign pl_adj = pl_r + (pl_r[EP_W-1] ? EP_W'(8191) : '0);
  assign pt_adj = pt_r + (pt_r[EP_W-1] ? EP_W'(8191) : '0);
  assign pw_adj = pw_r + (pw_r[SP_W-1] ? SP_W'(4095) : '0);
  assign ph_adj = ph_r + (ph_r[SP_W-1] ? SP_W'(4095) : '0);

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      l2_r <= EQ_W'(pl_adj >>> 13);
      t2_r <= EQ_W'(pt_adj >>> 13);
      w2_r <= SQ_W'(pw_adj >>> 12);
      h2_r <= SQ_W'(ph_adj >>> 12);
    end
  end

  // stage 3: corner into [0, dim-1], size into [1, 4096]
  logic signed [EQ_W-1:0] lim_x, lim_y;
  logic [drd_pkg::POS_W-1:0] l3_nxt, t3_nxt, l3_r, t3_r;
  logic [drd_pkg::DIM_W-1:0] w3_nxt, h3_nxt, w3_r, h3_r;

  assign lim_x = signed'(EQ_W'(iw)) - EQ_W'(1);
  assign lim_y = signed'(EQ_W'(ih)) - EQ_W'(1);

  always_comb begin
    if (l2_r < 0)          l3_nxt = '0;
    else if (l2_r > lim_x) l3_nxt = lim_x[drd_pkg::POS_W-1:0];
    else                   l3_nxt = l2_r[drd_pkg::POS_W-1:0];
    if (t2_r < 0)          t3_nxt = '0;
    else if (t2_r > lim_y) t3_nxt = lim_y[drd_pkg::POS_W-1:0];
    else                   t3_nxt = t2_r[drd_pkg::POS_W-1:0];
    if (w2_r < SQ_W'(1))                          w3_nxt = drd_pkg::DIM_MIN;
    else if (w2_r > signed'(SQ_W'(drd_pkg::DIM_MAX))) w3_nxt = drd_pkg::DIM_MAX;
    else                                          w3_nxt = w2_r[drd_pkg::DIM_W-1:0];
    if (h2_r < SQ_W'(1))                          h3_nxt = drd_pkg::DIM_MIN;
    else if (h2_r > signed'(SQ_W'(drd_pkg::DIM_MAX))) h3_nxt = drd_pkg::DIM_MAX;
    else                                          h3_nxt = h2_r[drd_pkg::DIM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      l3_r <= l3_nxt;
      t3_r <= t3_nxt;
      w3_r <= w3_nxt;
      h3_r <= h3_nxt;
    end
  end

  // stage 4: size no larger than what is left of the image
  logic [drd_pkg::DIM_W-1:0] room_x, room_y;

  assign room_x = iw - drd_pkg::DIM_W'(l3_r);
  assign room_y = ih - drd_pkg::DIM_W'(t3_r);

  always_ff @(posedge clk) begin
    if (ld.ld4) begin
      left_r <= l3_r;
      top_r  <= t3_r;
      wd_r   <= (w3_r > room_x) ? room_x : w3_r;
      ht_r   <= (h3_r > room_y) ? room_y : h3_r;
    end
  end

endmodule

/* rtl/detector_row_decode_top.sv */
// ---------------------------------------------------------------------------
// detector_row_decode_top: detector output row decoder
// Scales class scores by objectness (if enabled) in parallel lanes, merges to the
// best class, drops rows under threshold, and emits a clamped pixel box.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  center_x, center_y, box_w, box_h,
//                                objectness, score_0 .. score_5
//  out      out_valid/out_stall  class_id, confidence, left, top,
//                                width, height
//  cfg      cfg_we               cfg_index, cfg_wdata
//
//  One row per cycle while in_stall is low. A kept row raises out_valid
//  from the last of four register stages: lane multiply, merge/truncate,
//  clamp, size fit. A dropped row leaves the pipe at the merge stage.
//  rst_n is synchronous: it clears all stage valids and loads register
//  defaults. out_stall backs the pipe up only as far as bubbles allow.
// ---------------------------------------------------------------------------
module detector_row_decode_top #(
  parameter int NUM_CLASSES = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [drd_pkg::COORD_W-1:0]  in_center_x,
  input  logic signed [drd_pkg::COORD_W-1:0]  in_center_y,
  input  logic signed [drd_pkg::COORD_W-1:0]  in_box_w,
  input  logic signed [drd_pkg::COORD_W-1:0]  in_box_h,
  input  logic [drd_pkg::SCORE_W-1:0]         in_objectness,
  input  logic [drd_pkg::SCORE_W-1:0]         in_score_0,
  input  logic [drd_pkg::SCORE_W-1:0]         in_score_1,
  input  logic [drd_pkg::SCORE_W-1:0]         in_score_2,
  input  logic [drd_pkg::SCORE_W-1:0]         in_score_3,
  input  logic [drd_pkg::SCORE_W-1:0]         in_score_4,
  input  logic [drd_pkg::SCORE_W-1:0]         in_score_5,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [drd_pkg::CLASS_W-1:0]         out_class_id,
  output logic [drd_pkg::SCORE_W-1:0]         out_confidence,
  output logic [drd_pkg::POS_W-1:0]           out_left,
  output logic [drd_pkg::POS_W-1:0]           out_top,
  output logic [drd_pkg::DIM_W-1:0]           out_width,
  output logic [drd_pkg::DIM_W-1:0]           out_height,

  input  logic                                cfg_we,
  input  logic [drd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [drd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // ---- configuration registers ----
  drd_pkg::thr_t               thr_r;
  logic                        obj_en_r;
  logic [drd_pkg::SCALE_W-1:0] scale_r;
  logic [drd_pkg::DIM_W-1:0]   img_w_r, img_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.ball     <= 16'd13107;
      thr_r.goalpost <= 16'd32768;
      thr_r.robot    <= 16'd13107;
      thr_r.crossing <= 16'd26214;
      obj_en_r       <= 1'b0;
      scale_r        <= 16'd256;
      img_w_r        <= 13'd640;
      img_h_r        <= 13'd480;
    end else if (cfg_we) begin
      unique case (drd_pkg::cfg_reg_t'(cfg_index))
        drd_pkg::REG_BALL_THR:  thr_r.ball     <= cfg_wdata;
        drd_pkg::REG_GOAL_THR:  thr_r.goalpost <= cfg_wdata;
        drd_pkg::REG_ROBOT_THR: thr_r.robot    <= cfg_wdata;
        drd_pkg::REG_CROSS_THR: thr_r.crossing <= cfg_wdata;
        drd_pkg::REG_OBJ_EN:    obj_en_r       <= cfg_wdata[0];
        drd_pkg::REG_BOX_SCALE: scale_r        <= cfg_wdata;
        drd_pkg::REG_IMG_W:     img_w_r        <= cfg_wdata[drd_pkg::DIM_W-1:0];
        drd_pkg::REG_IMG_H:     img_h_r        <= cfg_wdata[drd_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // image size used for clamping: zero reads as 1, above 4096 as 4096
  logic [drd_pkg::DIM_W-1:0] iw, ih;

  always_comb begin
    if (img_w_r == '0)                  iw = drd_pkg::DIM_MIN;
    else if (img_w_r > drd_pkg::DIM_MAX) iw = drd_pkg::DIM_MAX;
    else                                iw = img_w_r;
    if (img_h_r == '0)                  ih = drd_pkg::DIM_MIN;
    else if (img_h_r > drd_pkg::DIM_MAX) ih = drd_pkg::DIM_MAX;
    else                                ih = img_h_r;
  end

  // ---- pipeline flow control ----
  // A stage loads when it is empty or its contents move on this cycle.
  logic v1_r, v2_r, v3_r, v4_r;
  logic free1, free2, free3, free4;
  logic pass;
  drd_pkg::pipe_ld_t ld;

  assign free4 = !v4_r || !out_stall;
  assign free3 = !v3_r || free4;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;

  assign ld.ld1 = free1;
  assign ld.ld2 = free2;
  assign ld.ld3 = free3;
  assign ld.ld4 = free4;

  assign in_stall  = !free1;
  assign out_valid = v4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_valid;
      if (free2) v2_r <= v1_r && pass;   // under-threshold rows die here
      if (free3) v3_r <= v2_r;
      if (free4) v4_r <= v3_r;
    end
  end

  // ---- class lanes ----
  logic [drd_pkg::SCORE_W-1:0] score_in  [drd_pkg::MAX_CLASSES];
  logic [drd_pkg::SCORE_W-1:0] lane_score [NUM_CLASSES];

  assign score_in[0] = in_score_0;
  assign score_in[1] = in_score_1;
  assign score_in[2] = in_score_2;
  assign score_in[3] = in_score_3;
  assign score_in[4] = in_score_4;
  assign score_in[5] = in_score_5;

  for (genvar c = 0; c < NUM_CLASSES; c++) begin : g_lane
    drd_lane u_lane (
      .clk     (clk),
      .ld      (ld.ld1),
      .obj_en  (obj_en_r),
      .obj     (in_objectness),
      .score   (score_in[c]),
      .score_r (lane_score[c])
    );
  end

  // ---- merge ----
  drd_pkg::det_t det2_r, det3_r, det4_r;

  drd_merge #(
    .NUM_CLASSES (NUM_CLASSES)
  ) u_merge (
    .clk    (clk),
    .ld     (ld.ld2),
    .thr    (thr_r),
    .scores (lane_score),
    .pass   (pass),
    .best_r (det2_r)
  );

  // class and score ride alongside the box stages
  always_ff @(posedge clk) begin
    if (ld.ld3) det3_r <= det2_r;
    if (ld.ld4) det4_r <= det3_r;
  end

  // ---- box ----
  drd_box u_box (
    .clk    (clk),
    .ld     (ld),
    .cx     (in_center_x),
    .cy     (in_center_y),
    .bw     (in_box_w),
    .bh     (in_box_h),
    .scale  (scale_r),
    .iw     (iw),
    .ih     (ih),
    .left_r (out_left),
    .top_r  (out_top),
    .wd_r   (out_width),
    .ht_r   (out_height)
  );

  assign out_class_id   = det4_r.cls;
  assign out_confidence = det4_r.conf;

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r)
    else $error("input stalled with stage 1 empty");

  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !free3 |=> v2_r)
    else $error("blocked merge result lost");

  a_class_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_class_id < drd_pkg::CLASS_W'(NUM_CLASSES)))
    else $error("class index out of range");

  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_width != '0) && (out_height != '0))
    else $error("zero box size on output");
`endif

endmodule
